// ===== rtl/core/log_bucket_timeout_queue_defines.svh =====
// Assertion macros shared by the timeout queue RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef LOG_BUCKET_TIMEOUT_QUEUE_DEFINES_SVH
`define LOG_BUCKET_TIMEOUT_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LBTQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LBTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/lbtq_pkg.sv =====
// Shared types, codes and helpers for the timeout queue.
// No dependencies; used by lbtq_ctrl, lbtq_dp and the top level.
`default_nettype none
package lbtq_pkg;

   localparam logic [1:0] ACT_ADD     = 2'd0;
   localparam logic [1:0] ACT_CANCEL  = 2'd1;
   localparam logic [1:0] ACT_RESTART = 2'd2;
   localparam logic [1:0] ACT_PROCESS = 2'd3;

   localparam logic [2:0] KIND_ADDED   = 3'd0;
   localparam logic [2:0] KIND_FULL    = 3'd1;
   localparam logic [2:0] KIND_DONE    = 3'd2;
   localparam logic [2:0] KIND_BAD     = 3'd3;
   localparam logic [2:0] KIND_EXPIRED = 3'd4;
   localparam logic [2:0] KIND_WAIT    = 3'd5;

   localparam int TIME_W = 48;

   typedef struct packed {
      logic       capture;
      logic       add_commit;
      logic       cancel_commit;
      logic       restart_commit;
      logic       idx_inc;
      logic       bkt_inc;
      logic       bucket_start;
      logic       eval;
      logic       expire;
      logic       bucket_done;
      logic       emit;
      logic [2:0] emit_kind;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic [1:0] held_action;
      logic       idx_last;
      logic       bkt_last;
      logic       idx_free;
      logic       handle_bad;
      logic       ent_match;
      logic       ent_expired;
      logic       due_active;
      logic       rsp_free;
   } status_type;

   // Position of the highest set bit; 0 for inputs 0 and 1.
   function automatic logic [5:0] log2_floor(input logic [TIME_W-1:0] t);
      logic [5:0] n;
      n = 6'd0;
      for (int i = 1; i < TIME_W; i++) begin
         if (t[i]) n = 6'(i);
      end
      return n;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/log_bucket_timeout_queue.sv =====
// Top level of the logarithmic bucket timeout queue.
// Depends on lbtq_pkg, lbtq_ctrl and lbtq_dp.
//
//   channel | handshake            | payload
//   req     | req_valid/req_ready  | action, handle, delay, now
//   rsp     | rsp_valid/rsp_ready  | kind, handle_res, wait_ticks, none_pending,
//           |                      | entry_count, last
//
// Add checks valid bits one at a time for the lowest free entry. Process scans
// every entry for each bucket through the single registered read port of the
// entry memories.
// A result beat that is not taken stalls the scan at the next entry to expire.
// Reset clears valid bits, bucket due marks and the live count.
`default_nettype none
module log_bucket_timeout_queue #(
   parameter int ENTRIES = 32,
   parameter int BUCKETS = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [1:0]  req_action,
   input  wire  [4:0]  req_handle,
   input  wire  [31:0] req_delay,
   input  wire  [46:0] req_now,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [4:0]  rsp_handle_res,
   output logic [31:0] rsp_wait_ticks,
   output logic        rsp_none_pending,
   output logic [5:0]  rsp_entry_count,
   output logic        rsp_last
);

   lbtq_pkg::cmd_type    cmd;
   lbtq_pkg::status_type st;

   lbtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   lbtq_dp #(
      .ENTRIES (ENTRIES),
      .BUCKETS (BUCKETS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_action       (req_action),
      .req_handle       (req_handle),
      .req_delay        (req_delay),
      .req_now          (req_now),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_handle_res   (rsp_handle_res),
      .rsp_wait_ticks   (rsp_wait_ticks),
      .rsp_none_pending (rsp_none_pending),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire

// ===== rtl/core/lbtq_ctrl.sv =====
// Sequencer for the timeout queue: walks requests, bucket and entry scans.
// Depends on lbtq_pkg; drives lbtq_dp through cmd_type, reads status_type.
`default_nettype none
module lbtq_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  lbtq_pkg::status_type st,
   output lbtq_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_ADD, S_EDIT, S_PBKT, S_PRD, S_PEVAL, S_PDONE, S_PFIN
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (st.action)
                  lbtq_pkg::ACT_ADD:     state_in = S_ADD;
                  lbtq_pkg::ACT_PROCESS: state_in = S_PBKT;
                  default:               state_in = S_EDIT;
               endcase
            end
         end
         S_ADD: begin
            if (st.idx_free) begin
               if (st.rsp_free) begin
                  cmd.add_commit = 1'b1;
                  cmd.emit       = 1'b1;
                  cmd.emit_kind  = lbtq_pkg::KIND_ADDED;
                  cmd.emit_last  = 1'b1;
                  state_in       = S_IDLE;
               end
            end else if (st.idx_last) begin
               if (st.rsp_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = lbtq_pkg::KIND_FULL;
                  cmd.emit_last = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_EDIT: begin
            if (st.rsp_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
               if (st.handle_bad) begin
                  cmd.emit_kind = lbtq_pkg::KIND_BAD;
               end else begin
                  cmd.emit_kind      = lbtq_pkg::KIND_DONE;
                  cmd.cancel_commit  = (st.held_action == lbtq_pkg::ACT_CANCEL);
                  cmd.restart_commit = (st.held_action != lbtq_pkg::ACT_CANCEL);
               end
            end
         end
         S_PBKT: begin
            cmd.bucket_start = 1'b1;
            state_in         = S_PRD;
         end
         S_PRD: begin
            state_in = S_PEVAL;
         end
         S_PEVAL: begin
            if (st.ent_match && st.due_active && st.ent_expired) begin
               // hold the entry until the expiry beat has room
               if (st.rsp_free) begin
                  cmd.expire    = 1'b1;
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = lbtq_pkg::KIND_EXPIRED;
                  state_in      = st.idx_last ? S_PDONE : S_PRD;
                  cmd.idx_inc   = !st.idx_last;
               end
            end else begin
               cmd.eval    = 1'b1;
               state_in    = st.idx_last ? S_PDONE : S_PRD;
               cmd.idx_inc = !st.idx_last;
            end
         end
         S_PDONE: begin
            cmd.bucket_done = 1'b1;
            cmd.bkt_inc     = !st.bkt_last;
            state_in        = st.bkt_last ? S_PFIN : S_PBKT;
         end
         S_PFIN: begin
            if (st.rsp_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = lbtq_pkg::KIND_WAIT;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/lbtq_dp.sv =====
// Datapath of the timeout queue: entry memories, valid bits, bucket due
// times, scan counters and the result register. Depends on lbtq_pkg.
`default_nettype none
`include "log_bucket_timeout_queue_defines.svh"
module lbtq_dp #(
   parameter int ENTRIES = 32,
   parameter int BUCKETS = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   input  lbtq_pkg::cmd_type     cmd,
   output lbtq_pkg::status_type  st,
   input  wire  [1:0]            req_action,
   input  wire  [4:0]            req_handle,
   input  wire  [31:0]           req_delay,
   input  wire  [46:0]           req_now,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic [2:0]            rsp_kind,
   output logic [4:0]            rsp_handle_res,
   output logic [31:0]           rsp_wait_ticks,
   output logic                  rsp_none_pending,
   output logic [5:0]            rsp_entry_count,
   output logic                  rsp_last
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int BW = $clog2(BUCKETS);
   localparam int TW = lbtq_pkg::TIME_W;

   logic [1:0]    action_ff;
   logic [4:0]    handle_ff;
   logic [31:0]   delay_ff;
   logic [46:0]   now_ff;
   logic [IW-1:0] idx_ff, idx_in;
   logic [BW-1:0] bkt_ff, bkt_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [5:0]    live_ff, live_in;
   logic [BUCKETS-1:0] due_vld_ff;
   logic [TW-1:0] due_ff [BUCKETS];
   logic          due_active_ff;
   logic [TW-1:0] best_ff, best_in;
   logic          best_none_ff, best_none_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic [TW-1:0] only_ff, only_in;

   logic [TW-1:0] dl_mem [ENTRIES];
   logic [BW-1:0] bk_mem [ENTRIES];
   logic [TW-1:0] dl_rd_ff;
   logic [BW-1:0] bk_rd_ff;

   logic          rsp_valid_ff;
   logic [2:0]    rsp_kind_ff;
   logic [4:0]    rsp_handle_ff;
   logic [31:0]   rsp_wait_ff;
   logic          rsp_none_ff;
   logic [5:0]    rsp_count_ff;
   logic          rsp_last_ff;

   logic [5:0]    h6;
   logic [IW-1:0] hidx;
   logic [5:0]    idx6;
   logic [TW-1:0] now48;
   logic [TW-1:0] cur_due, new_due, due_eff, s_val, mask_val;
   logic [TW-1:0] remain;
   logic [BW-1:0] nb_sat, nb_delay, nb_eff;
   logic [5:0]    lg_rem, lg_delay;
   logic          match, expired;
   logic [48:0]   wait_lim;
   logic [31:0]   wait_val;
   logic          mem_we;
   logic [IW-1:0] mem_addr;
   logic [BW-1:0] bk_wdata;
   logic          dl_we;

   assign h6    = 6'(handle_ff);
   assign hidx  = h6[IW-1:0];
   assign idx6  = 6'(idx_ff);
   assign now48 = {1'b0, now_ff};

   assign cur_due  = due_vld_ff[bkt_ff] ? due_ff[bkt_ff] : '0;
   assign s_val    = (TW'(1) << bkt_ff) >> 1;
   assign mask_val = ~TW'(0) << bkt_ff;
   assign new_due  = ((now48 + s_val) & mask_val) + s_val;
   assign due_eff  = due_active_ff ? new_due : cur_due;

   assign match   = valid_ff[idx_ff] && (bk_rd_ff == bkt_ff);
   assign expired = (dl_rd_ff <= now48);
   assign remain  = dl_rd_ff - now48;
   assign lg_rem  = lbtq_pkg::log2_floor(remain);
   assign lg_delay = lbtq_pkg::log2_floor(TW'(delay_ff));
   assign nb_sat   = (lg_rem > 6'(BUCKETS - 1)) ? BW'(BUCKETS - 1) : lg_rem[BW-1:0];
   assign nb_delay = (lg_delay > 6'(BUCKETS - 1)) ? BW'(BUCKETS - 1) : lg_delay[BW-1:0];
   assign nb_eff   = due_active_ff ? nb_sat : bk_rd_ff;

   assign wait_lim = 49'(now_ff) + 49'(32'hFFFF_FFFF);
   always_comb begin
      if (best_none_ff || ({1'b0, best_ff} >= wait_lim)) begin
         wait_val = 32'hFFFF_FFFF;
      end else if (best_ff <= now48) begin
         wait_val = 32'd0;
      end else begin
         wait_val = 32'(best_ff - now48);
      end
   end

   // status toward the sequencer
   always_comb begin
      st.action      = req_action;
      st.held_action = action_ff;
      st.idx_last    = (idx_ff == IW'(ENTRIES - 1));
      st.bkt_last    = (bkt_ff == BW'(BUCKETS - 1));
      st.idx_free    = !valid_ff[idx_ff];
      st.handle_bad  = (h6 >= 6'(ENTRIES)) || !valid_ff[hidx];
      st.ent_match   = match;
      st.ent_expired = expired;
      st.due_active  = due_active_ff;
      st.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // memory write port
   always_comb begin
      mem_we   = cmd.add_commit || cmd.restart_commit ||
                 (cmd.eval && match && due_active_ff);
      dl_we    = cmd.add_commit || cmd.restart_commit;
      mem_addr = cmd.restart_commit ? hidx : idx_ff;
      bk_wdata = cmd.eval ? nb_sat : nb_delay;
   end

   always_comb begin
      idx_in       = idx_ff;
      bkt_in       = bkt_ff;
      valid_in     = valid_ff;
      live_in      = live_ff;
      best_in      = best_ff;
      best_none_in = best_none_ff;
      cnt_in       = cnt_ff;
      only_in      = only_ff;
      if (cmd.capture) begin
         idx_in       = '0;
         bkt_in       = '0;
         best_none_in = 1'b1;
      end
      if (cmd.bucket_start) begin
         idx_in = '0;
         cnt_in = 2'd0;
      end
      if (cmd.idx_inc) idx_in = idx_ff + IW'(1);
      if (cmd.bkt_inc) bkt_in = bkt_ff + BW'(1);
      if (cmd.add_commit) begin
         valid_in[idx_ff] = 1'b1;
         live_in          = live_ff + 6'd1;
      end
      if (cmd.cancel_commit) begin
         valid_in[hidx] = 1'b0;
         live_in        = live_ff - 6'd1;
      end
      if (cmd.expire) begin
         valid_in[idx_ff] = 1'b0;
         live_in          = live_ff - 6'd1;
      end
      if (cmd.eval && match) begin
         if (due_active_ff && (best_none_ff || (dl_rd_ff < best_ff))) begin
            best_in      = dl_rd_ff;
            best_none_in = 1'b0;
         end
         if (nb_eff == bkt_ff) begin
            cnt_in  = (cnt_ff == 2'd2) ? 2'd2 : cnt_ff + 2'd1;
            only_in = dl_rd_ff;
         end
      end
      if (cmd.bucket_done && (best_none_ff || (due_eff < best_ff))) begin
         if (cnt_ff == 2'd2) begin
            best_in      = due_eff;
            best_none_in = 1'b0;
         end else if (cnt_ff == 2'd1 && (best_none_ff || (only_ff < best_ff))) begin
            best_in      = only_ff;
            best_none_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         handle_ff <= req_handle;
         delay_ff  <= req_delay;
         now_ff    <= req_now;
      end
      if (mem_we) bk_mem[mem_addr] <= bk_wdata;
      if (dl_we)  dl_mem[mem_addr] <= now48 + TW'(delay_ff);
      dl_rd_ff <= dl_mem[idx_ff];
      bk_rd_ff <= bk_mem[idx_ff];
      if (cmd.bucket_start) due_active_ff <= (cur_due <= now48);
      if (cmd.bucket_done && due_active_ff) due_ff[bkt_ff] <= new_due;
      idx_ff       <= idx_in;
      bkt_ff       <= bkt_in;
      best_ff      <= best_in;
      best_none_ff <= best_none_in;
      cnt_ff       <= cnt_in;
      only_ff      <= only_in;
      if (cmd.emit) begin
         rsp_kind_ff   <= cmd.emit_kind;
         rsp_handle_ff <= (cmd.emit_kind == lbtq_pkg::KIND_ADDED ||
                           cmd.emit_kind == lbtq_pkg::KIND_EXPIRED) ? idx6[4:0] : 5'd0;
         rsp_wait_ff   <= (cmd.emit_kind == lbtq_pkg::KIND_WAIT) ? wait_val : 32'd0;
         rsp_none_ff   <= (live_in == 6'd0);
         rsp_count_ff  <= live_in;
         rsp_last_ff   <= cmd.emit_last;
      end
      if (reset) begin
         valid_ff     <= '0;
         live_ff      <= 6'd0;
         due_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         live_ff  <= live_in;
         if (cmd.bucket_done && due_active_ff) due_vld_ff[bkt_ff] <= 1'b1;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_handle_res   = rsp_handle_ff;
   assign rsp_wait_ticks   = rsp_wait_ff;
   assign rsp_none_pending = rsp_none_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_last         = rsp_last_ff;

   `LBTQ_ASSERT_NOW(a_live_matches_valid, clock, reset, 1'b1,
      32'(live_ff) == 32'($countones(valid_ff)), "live count differs from valid bits")
   `LBTQ_ASSERT_NOW(a_emit_has_room, clock, reset, cmd.emit,
      !rsp_valid_ff || rsp_ready, "result beat overwritten before taken")
   `LBTQ_ASSERT_NEXT(a_add_sets_valid, clock, reset, cmd.add_commit,
      valid_ff[$past(idx_ff)], "added entry not marked live")

endmodule
`default_nettype wire
